@@ design/lvcp_pkg.sv @@
// shared types and constants of the letter/value command parser
package lvcp_pkg;

  localparam int unsigned WHOLE_W    = 27;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WHOLE_W-1:0] WHOLE_SAT = 27'd99999999;

  // request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDEAL_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDEAL_MAX = 2'd3;

  // register reset values
  localparam logic [1:0]         VARIANT_RST   = 2'd2;
  localparam logic [7:0]         TIMEOUT_RST   = 8'd5;
  localparam logic signed [15:0] IDEAL_MIN_RST = -16'sd1000;
  localparam logic signed [15:0] IDEAL_MAX_RST = 16'sd1000;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_X     = 8'h58;

  // position map: input span -500 .. 500
  localparam logic [WHOLE_W-1:0] MAP_OFFSET = 27'd500;
  localparam logic [9:0]         MAP_SPAN   = 10'd1000;

  typedef enum logic [2:0] {
    TGT_P_GAIN   = 3'd0,
    TGT_I_GAIN   = 3'd1,
    TGT_D_GAIN   = 3'd2,
    TGT_SPEED    = 3'd3,
    TGT_POSITION = 3'd4,
    TGT_SUCTION  = 3'd5
  } target_e;

  typedef struct packed {
    target_e            target;
    logic               negative;
    logic [WHOLE_W-1:0] whole;
  } cmd_t;

endpackage

@@ design/lvcp_parser.sv @@
// byte/tick parser: pending letter, decimal accumulation and silence timer
module lvcp_parser #(
  parameter int unsigned FRAC_MAX = 6,
  localparam int unsigned FRAC_W = $clog2(10 ** FRAC_MAX),
  localparam int unsigned CNT_W  = $clog2(FRAC_MAX + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              req_type_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [1:0]        variant_i,
  input  logic [7:0]        timeout_i,
  output logic              emit_o,
  output lvcp_pkg::cmd_t    cmd_o,
  output logic [FRAC_W-1:0] frac_o,
  output logic [CNT_W-1:0]  cnt_o
);
  import lvcp_pkg::*;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_INT   = 4'b0010,
    PH_FRAC  = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  logic [7:0]         pend_q, pend_d;
  phase_e             phase_q, phase_d;
  logic               sign_q, sign_d;
  logic [WHOLE_W-1:0] whole_q, whole_d;
  logic [FRAC_W-1:0]  frac_q, frac_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [7:0]         sil_q, sil_d;

  logic               is_digit, is_num, fire, clr, known;
  logic [3:0]         digit;
  logic [30:0]        w10;
  logic [FRAC_W+3:0]  f10;
  logic [8:0]         sil_inc;
  target_e            tgt;

  assign is_digit = (rx_byte_i >= CH_ZERO) && (rx_byte_i <= CH_NINE);
  assign is_num   = is_digit || (rx_byte_i == CH_DOT) || (rx_byte_i == CH_MINUS);
  assign digit    = rx_byte_i[3:0];
  assign w10      = (31'(whole_q) << 3) + (31'(whole_q) << 1) + 31'(digit);
  assign f10      = ((FRAC_W+4)'(frac_q) << 3) + ((FRAC_W+4)'(frac_q) << 1)
                  + (FRAC_W+4)'(digit);
  assign sil_inc  = 9'(sil_q) + 9'd1;

  // letter decode, gated by variant
  always_comb begin
    known = 1'b1;
    tgt   = TGT_P_GAIN;
    unique case (pend_q)
      CH_P:    tgt = TGT_P_GAIN;
      CH_I:    tgt = TGT_I_GAIN;
      CH_D:    tgt = TGT_D_GAIN;
      CH_V:    tgt = TGT_SPEED;
      CH_X: begin
        tgt   = TGT_POSITION;
        known = (variant_i != 2'd0);
      end
      CH_S: begin
        tgt   = TGT_SUCTION;
        known = (variant_i >= 2'd2);
      end
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    pend_d  = pend_q;
    phase_d = phase_q;
    sign_d  = sign_q;
    whole_d = whole_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    sil_d   = sil_q;
    fire    = 1'b0;
    clr     = 1'b0;
    if (accept_i) begin
      if (req_type_i == REQ_BYTE) begin
        sil_d = '0;
        if (is_num) begin
          unique case (phase_q) inside
            PH_START, PH_INT: begin
              if (is_digit) begin
                whole_d = (w10 > 31'(WHOLE_SAT)) ? WHOLE_SAT : w10[WHOLE_W-1:0];
                phase_d = PH_INT;
              end else if (rx_byte_i == CH_DOT) begin
                phase_d = PH_FRAC;
              end else if (phase_q == PH_START) begin
                sign_d  = 1'b1;
                phase_d = PH_INT;
              end else begin
                phase_d = PH_DONE;
              end
            end
            PH_FRAC: begin
              if (is_digit) begin
                if (cnt_q < CNT_W'(FRAC_MAX)) begin
                  frac_d = f10[FRAC_W-1:0];
                  cnt_d  = cnt_q + CNT_W'(1);
                end
              end else begin
                phase_d = PH_DONE;
              end
            end
            PH_DONE: ;
            default: ;
          endcase
        end else begin
          // any other byte runs the pending letter and becomes the new one
          fire   = (pend_q != CH_SPACE);
          pend_d = rx_byte_i;
          clr    = 1'b1;
        end
      end else begin
        sil_d = sil_inc[8] ? 8'hFF : sil_inc[7:0];
        if ((sil_inc > 9'(timeout_i)) && (pend_q != CH_SPACE)) begin
          fire   = 1'b1;
          pend_d = CH_SPACE;
          clr    = 1'b1;
        end
      end
    end
    if (clr) begin
      phase_d = PH_START;
      sign_d  = 1'b0;
      whole_d = '0;
      frac_d  = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= CH_SPACE;
      phase_q <= PH_START;
      sign_q  <= 1'b0;
      whole_q <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
      sil_q   <= '0;
    end else begin
      pend_q  <= pend_d;
      phase_q <= phase_d;
      sign_q  <= sign_d;
      whole_q <= whole_d;
      frac_q  <= frac_d;
      cnt_q   <= cnt_d;
      sil_q   <= sil_d;
    end
  end

  // snapshot of the number as it stood before this word
  assign emit_o          = fire && known;
  assign cmd_o.target    = tgt;
  assign cmd_o.negative  = sign_q;
  assign cmd_o.whole     = whole_q;
  assign frac_o          = frac_q;
  assign cnt_o           = cnt_q;

endmodule

@@ design/lvcp_result_pipe.sv @@
// result pipeline: position map arithmetic and output register
module lvcp_result_pipe #(
  parameter int unsigned FRAC_MAX = 6,
  localparam int unsigned FRAC_W = $clog2(10 ** FRAC_MAX),
  localparam int unsigned CNT_W  = $clog2(FRAC_MAX + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                emit_i,
  input  lvcp_pkg::cmd_t      cmd_i,
  input  logic [FRAC_W-1:0]   frac_i,
  input  logic [CNT_W-1:0]    cnt_i,
  input  logic signed [15:0]  ideal_min_i,
  input  logic signed [15:0]  ideal_max_i,
  output logic                take_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output lvcp_pkg::cmd_t      cmd_o,
  output logic [FRAC_W-1:0]   frac_o,
  output logic [CNT_W-1:0]    cnt_o,
  output logic signed [31:0]  int_o
);
  import lvcp_pkg::*;

  localparam int unsigned NSTG = 8;
  // exact floor(n / 1000) for 27-bit and 26-bit n
  localparam logic [27:0] RECIP_U = 28'd137438954;
  localparam logic [26:0] RECIP_B = 27'd68719477;

  logic [NSTG-1:0]   v_q;
  logic [NSTG-1:0]   en;
  cmd_t              cmd_q  [NSTG];
  logic [FRAC_W-1:0] frac_q [NSTG];
  logic [CNT_W-1:0]  cnt_q  [NSTG];

  logic [WHOLE_W-1:0] mu1_q, mu2_q, mu_d;
  logic               un1_q, un2_q, un3_q, un4_q, un5_q, un_d;
  logic [16:0]        qu2_q, qu3_q;
  logic [9:0]         ru3_q;
  logic [32:0]        a4_q, a5_q;
  logic [25:0]        b4_q;
  logic [15:0]        c5_q;
  logic [33:0]        mq6_q;
  logic               pn6_q;
  logic signed [31:0] int_q, int_d;

  logic [54:0]        prod_u;
  logic [52:0]        prod_b;
  logic [WHOLE_W-1:0] rem_full;
  logic signed [16:0] diff;
  logic [16:0]        diff_abs;
  logic [15:0]        dmag;
  logic signed [34:0] q_s;
  logic signed [35:0] sum_s;
  logic signed [31:0] trunc;

  // a stage loads when empty or when the stage after it moves on
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end
  assign take_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= emit_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cmd_q[0]  <= cmd_i;
      frac_q[0] <= frac_i;
      cnt_q[0]  <= cnt_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        cmd_q[k]  <= cmd_q[k-1];
        frac_q[k] <= frac_q[k-1];
        cnt_q[k]  <= cnt_q[k-1];
      end
    end
  end

  // |value + 500| and its sign
  always_comb begin
    if (!cmd_q[0].negative) begin
      mu_d = cmd_q[0].whole + MAP_OFFSET;
      un_d = 1'b0;
    end else if (cmd_q[0].whole <= MAP_OFFSET) begin
      mu_d = MAP_OFFSET - cmd_q[0].whole;
      un_d = 1'b0;
    end else begin
      mu_d = cmd_q[0].whole - MAP_OFFSET;
      un_d = 1'b1;
    end
  end

  // span of the map, split into sign and magnitude
  assign diff     = {ideal_max_i[15], ideal_max_i} - {ideal_min_i[15], ideal_min_i};
  assign diff_abs = diff[16] ? (17'd0 - 17'(diff)) : 17'(diff);
  assign dmag     = diff_abs[15:0];

  assign prod_u   = 55'(mu1_q) * 55'(RECIP_U);
  assign rem_full = mu2_q - (27'(qu2_q) * 27'(MAP_SPAN));
  assign prod_b   = 53'(b4_q) * 53'(RECIP_B);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      mu1_q <= mu_d;
      un1_q <= un_d;
    end
    if (en[2]) begin
      qu2_q <= prod_u[53:37];
      mu2_q <= mu1_q;
      un2_q <= un1_q;
    end
    if (en[3]) begin
      qu3_q <= qu2_q;
      ru3_q <= rem_full[9:0];
      un3_q <= un2_q;
    end
    if (en[4]) begin
      a4_q  <= 33'(qu3_q) * 33'(dmag);
      b4_q  <= 26'(ru3_q) * 26'(dmag);
      un4_q <= un3_q;
    end
    if (en[5]) begin
      a5_q  <= a4_q;
      c5_q  <= prod_b[51:36];
      un5_q <= un4_q;
    end
    if (en[6]) begin
      mq6_q <= 34'(a5_q) + 34'(c5_q);
      pn6_q <= un5_q ^ diff[16];
    end
    if (en[7]) begin
      int_q <= int_d;
    end
  end

  // final sign, offset and saturation
  assign q_s   = pn6_q ? -$signed({1'b0, mq6_q}) : $signed({1'b0, mq6_q});
  assign sum_s = $signed({q_s[34], q_s}) + $signed({{20{ideal_min_i[15]}}, ideal_min_i});
  assign trunc = cmd_q[6].negative ? -$signed({5'b0, cmd_q[6].whole})
                                   : $signed({5'b0, cmd_q[6].whole});

  always_comb begin
    case (cmd_q[6].target) inside
      TGT_SPEED, TGT_SUCTION: int_d = trunc;
      TGT_POSITION: begin
        if (sum_s > 36'sd2147483647) begin
          int_d = 32'sh7FFFFFFF;
        end else if (sum_s < -36'sd2147483648) begin
          int_d = 32'sh80000000;
        end else begin
          int_d = sum_s[31:0];
        end
      end
      default: int_d = '0;
    endcase
  end

  assign out_valid_o = v_q[NSTG-1];
  assign cmd_o       = cmd_q[NSTG-1];
  assign frac_o      = frac_q[NSTG-1];
  assign cnt_o       = cnt_q[NSTG-1];
  assign int_o       = int_q;

endmodule

@@ design/letter_value_command_parser.sv @@
// top level of the letter/value command parser
//
// usage:
// - input channel (in_valid_i / in_stall_o): one word per received byte
//   (req_type_i = 0, rx_byte_i holds the character) or per millisecond tick
//   (req_type_i = 1). a word is taken when in_valid_i is high and in_stall_o low
// - output channel (out_valid_o / out_stall_i): one word per executed command,
//   carrying target, sign, integer part, fraction digits and an integer result
// - config channel (cfg_valid_i / cfg_ready_o): register index and write data;
//   cfg_ready_o is always high, write only while no command is in flight
// - throughput: one input word per clock while in_stall_o is low; the parser
//   state updates at the accepting edge, so back-to-back words are fine
// - pipeline: a result passes through the eight-stage result pipeline (map
//   multiply, two reciprocal divides by 1000, output register) before it
//   shows on out_valid_o
// - stalls: stages collapse bubbles; input stalls only when all eight stages
//   hold results and the receiver stalls
// - reset: no pending letter, empty number, silence count zero, registers at
//   their defaults (variant 2, timeout 5, map -1000 .. 1000), pipeline empty
module letter_value_command_parser #(
  parameter int unsigned FRAC_MAX = 6,
  localparam int unsigned FRAC_W = $clog2(10 ** FRAC_MAX),
  localparam int unsigned CNT_W  = $clog2(FRAC_MAX + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [7:0]                        rx_byte_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        target_o,
  output logic                              negative_o,
  output logic [lvcp_pkg::WHOLE_W-1:0]      whole_part_o,
  output logic [FRAC_W-1:0]                 fraction_digits_o,
  output logic [CNT_W-1:0]                  fraction_count_o,
  output logic signed [31:0]                int_result_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lvcp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lvcp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import lvcp_pkg::*;

  // configuration registers
  logic [1:0]         variant_q;
  logic [7:0]         timeout_q;
  logic signed [15:0] ideal_min_q;
  logic signed [15:0] ideal_max_q;

  logic               accept;
  logic               take;
  logic               emit;
  cmd_t               cmd_in, cmd_out;
  logic [FRAC_W-1:0]  frac_in;
  logic [CNT_W-1:0]   cnt_in;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q   <= VARIANT_RST;
      timeout_q   <= TIMEOUT_RST;
      ideal_min_q <= IDEAL_MIN_RST;
      ideal_max_q <= IDEAL_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_VARIANT:   variant_q   <= cfg_data_i[1:0];
        CFG_TIMEOUT:   timeout_q   <= cfg_data_i[7:0];
        CFG_IDEAL_MIN: ideal_min_q <= $signed(cfg_data_i);
        CFG_IDEAL_MAX: ideal_max_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // input is held off only when the first pipeline stage cannot load
  assign in_stall_o = !take;
  assign accept     = in_valid_i && !in_stall_o;

  lvcp_parser #(
    .FRAC_MAX (FRAC_MAX)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .rx_byte_i  (rx_byte_i),
    .variant_i  (variant_q),
    .timeout_i  (timeout_q),
    .emit_o     (emit),
    .cmd_o      (cmd_in),
    .frac_o     (frac_in),
    .cnt_o      (cnt_in)
  );

  lvcp_result_pipe #(
    .FRAC_MAX (FRAC_MAX)
  ) u_result_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .cmd_i       (cmd_in),
    .frac_i      (frac_in),
    .cnt_i       (cnt_in),
    .ideal_min_i (ideal_min_q),
    .ideal_max_i (ideal_max_q),
    .take_o      (take),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd_out),
    .frac_o      (fraction_digits_o),
    .cnt_o       (fraction_count_o),
    .int_o       (int_result_o)
  );

  assign target_o     = cmd_out.target;
  assign negative_o   = cmd_out.negative;
  assign whole_part_o = cmd_out.whole;

  // input backpressure only comes from a full pipeline behind a stalled receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result pipeline can move");

  // integer part saturated, fraction count bounded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((whole_part_o <= WHOLE_SAT)
                     && (fraction_count_o <= CNT_W'(FRAC_MAX))))
    else $error("result decimal out of range");

  // gain commands carry no integer result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (target_o < TGT_SPEED)) |-> (int_result_o == 32'sd0))
    else $error("gain result with nonzero integer");

  // speed result is the signed integer part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (target_o == TGT_SPEED)) |->
      (int_result_o == (negative_o ? -$signed({5'b0, whole_part_o})
                                   : $signed({5'b0, whole_part_o}))))
    else $error("speed result does not match the parsed value");

endmodule

@@ bench/letter_value_command_parser_tb.sv @@
// testbench of the letter/value command parser: directed words, then random commands checked by a predictor
`timescale 1ns / 1ps

module letter_value_command_parser_tb;
  import lvcp_pkg::*;

  localparam int unsigned FRAC_LIMIT    = 6;
  localparam int unsigned FRAC_BITS     = 20;
  localparam int unsigned COUNT_BITS    = 3;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_WORDS   = 140;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam longint MAP_HALF  = 500;
  localparam longint MAP_RANGE = 1000;
  localparam longint INT32_HI  = 64'sd2147483647;
  localparam longint INT32_LO  = -64'sd2147483648;

  // progress of the number that follows a letter
  typedef enum logic [1:0] {
    NUM_START,
    NUM_WHOLE,
    NUM_FRAC,
    NUM_DONE
  } num_state_e;

  // one result word as seen on the output ports
  typedef struct packed {
    target_e                target;
    logic                   negative;
    logic [WHOLE_W-1:0]     whole;
    logic [FRAC_BITS-1:0]   frac;
    logic [COUNT_BITS-1:0]  count;
    logic signed [31:0]     value;
  } result_t;

  // one directed word, with its result typed in where it is obvious
  typedef struct {
    logic       req;
    logic [7:0] ch;
    bit         typed;
    result_t    want;
  } stim_row_t;

  // clock, reset and block ports; every input starts at a known value
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  req_type_i  = REQ_BYTE;
  logic [7:0]            rx_byte_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [2:0]            target_o;
  logic                  negative_o;
  logic [WHOLE_W-1:0]    whole_part_o;
  logic [FRAC_BITS-1:0]  fraction_digits_o;
  logic [COUNT_BITS-1:0] fraction_count_o;
  logic signed [31:0]    int_result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // predictor copy of the parser state
  logic [7:0]            pend_letter;
  num_state_e            num_state;
  logic                  num_neg;
  logic [WHOLE_W-1:0]    num_whole;
  logic [FRAC_BITS-1:0]  num_frac;
  logic [COUNT_BITS-1:0] num_count;
  logic [7:0]            quiet_ticks;

  // predictor copy of the registers
  logic [1:0]            cfg_variant;
  logic [7:0]            cfg_timeout;
  logic signed [15:0]    cfg_lo;
  logic signed [15:0]    cfg_hi;

  // results still owed by the block, oldest first
  result_t     result_q[$];
  stim_row_t   stim_rows[$];
  result_t     seen_word;
  result_t     head_word;
  int unsigned mismatches  = 0;
  int unsigned words_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;

  letter_value_command_parser #(
    .FRAC_MAX(FRAC_LIMIT)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .target_o         (target_o),
    .negative_o       (negative_o),
    .whole_part_o     (whole_part_o),
    .fraction_digits_o(fraction_digits_o),
    .fraction_count_o (fraction_count_o),
    .int_result_o     (int_result_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic string fmt_word(input result_t w);
    return $sformatf("tgt=%0d neg=%0d whole=%0d frac=%0d cnt=%0d val=%0d",
                     w.target, w.negative, w.whole, w.frac, w.count, w.value);
  endfunction

  // result side: compare every accepted word with the oldest expectation,
  // and stall at the rate of the current phase
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_word.target   = target_e'(target_o);
      seen_word.negative = negative_o;
      seen_word.whole    = whole_part_o;
      seen_word.frac     = fraction_digits_o;
      seen_word.count    = fraction_count_o;
      seen_word.value    = int_result_o;
      if (result_q.size() == 0) begin
        $display("%0t: result mismatch, expected nothing, got %s",
                 $time, fmt_word(seen_word));
        mismatches++;
      end else begin
        head_word = result_q.pop_front();
        if (seen_word !== head_word) begin
          $display("%0t: result mismatch, expected %s, got %s",
                   $time, fmt_word(head_word), fmt_word(seen_word));
          mismatches++;
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_number();
    num_state = NUM_START;
    num_neg   = 1'b0;
    num_whole = '0;
    num_frac  = '0;
    num_count = '0;
  endfunction

  // digits, dot and minus: prefix rules, the first break ends the number
  function automatic void take_numeral(input logic [7:0] ch);
    logic        is_digit;
    logic [7:0]  dval;
    logic [63:0] grown;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dval = ch - CH_ZERO;
    case (num_state)
      NUM_START, NUM_WHOLE: begin
        if (is_digit) begin
          // integer part saturates instead of wrapping
          grown = num_whole * 64'd10 + dval;
          num_whole = (grown > WHOLE_SAT) ? WHOLE_SAT : grown[WHOLE_W-1:0];
          num_state = NUM_WHOLE;
        end else if (ch == CH_DOT) begin
          num_state = NUM_FRAC;
        end else if (num_state == NUM_START) begin
          // leading minus sign
          num_neg = 1'b1;
          num_state = NUM_WHOLE;
        end else begin
          num_state = NUM_DONE;
        end
      end
      NUM_FRAC: begin
        if (!is_digit) begin
          num_state = NUM_DONE;
        end else if (num_count < FRAC_LIMIT) begin
          // digits past the limit are dropped
          num_frac = num_frac * 20'd10 + dval;
          num_count = num_count + 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // result of the pending letter with the number so far, 0 if it gives none
  function automatic bit run_letter(input logic [7:0] letter, output result_t r);
    longint trunc;
    longint m;
    trunc = num_whole;
    if (num_neg) trunc = -trunc;
    m = 0;
    case (letter)
      CH_P: r.target = TGT_P_GAIN;
      CH_I: r.target = TGT_I_GAIN;
      CH_D: r.target = TGT_D_GAIN;
      CH_V: begin
        r.target = TGT_SPEED;
        m = trunc;
      end
      CH_X: begin
        if (cfg_variant == 2'd0) return 1'b0;
        r.target = TGT_POSITION;
        m = (trunc + MAP_HALF) * (longint'(cfg_hi) - longint'(cfg_lo)) / MAP_RANGE
            + longint'(cfg_lo);
        if (m > INT32_HI) m = INT32_HI;
        if (m < INT32_LO) m = INT32_LO;
      end
      CH_S: begin
        if (cfg_variant < 2'd2) return 1'b0;
        r.target = TGT_SUCTION;
        m = trunc;
      end
      default: return 1'b0;
    endcase
    r.negative = num_neg;
    r.whole    = num_whole;
    r.frac     = num_frac;
    r.count    = num_count;
    r.value    = m[31:0];
    return 1'b1;
  endfunction

  // one accepted input word; returns 1 when it causes a result word
  function automatic bit parse_word(input logic req, input logic [7:0] ch,
                                    output result_t r);
    bit         fired;
    logic [8:0] q;
    fired = 1'b0;
    if (req == REQ_BYTE) begin
      quiet_ticks = '0;
      if ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_DOT || ch == CH_MINUS) begin
        take_numeral(ch);
      end else begin
        // any other byte runs the pending letter and becomes the new one
        if (pend_letter != CH_SPACE) fired = run_letter(pend_letter, r);
        clear_number();
        pend_letter = ch;
      end
    end else begin
      // silence count saturates, compare uses the incremented count
      q = quiet_ticks + 9'd1;
      quiet_ticks = (q > 9'd255) ? 8'd255 : q[7:0];
      if (q > cfg_timeout && pend_letter != CH_SPACE) begin
        fired = run_letter(pend_letter, r);
        pend_letter = CH_SPACE;
        clear_number();
      end
    end
    return fired;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic void add_word(input logic req, input logic [7:0] ch);
    stim_row_t row;
    row.req   = req;
    row.ch    = ch;
    row.typed = 1'b0;
    row.want  = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_checked(input logic [7:0] ch, input target_e tgt,
                                      input logic neg, input logic [WHOLE_W-1:0] whole,
                                      input logic [FRAC_BITS-1:0] frac,
                                      input logic [COUNT_BITS-1:0] cnt,
                                      input logic signed [31:0] value);
    stim_row_t row;
    row.req            = REQ_BYTE;
    row.ch             = ch;
    row.typed          = 1'b1;
    row.want.target    = tgt;
    row.want.negative  = neg;
    row.want.whole     = whole;
    row.want.frac      = frac;
    row.want.count     = cnt;
    row.want.value     = value;
    stim_rows.push_back(row);
  endfunction

  // send one word with random idle cycles ahead of it, then record what it owes
  task automatic issue(input logic req, input logic [7:0] ch, input bit typed,
                       input result_t want);
    result_t r;
    bit      fired;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    rx_byte_i  <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fired = parse_word(req, ch, r);
    if (typed) result_q.push_back(want);
    else if (fired) result_q.push_back(r);
    words_sent++;
  endtask

  task automatic send_digits(input int unsigned n);
    repeat (n) issue(REQ_BYTE, CH_ZERO + 8'($urandom_range(0, 9)), 1'b0, '0);
  endtask

  // sender goes quiet until every owed result has come back
  task automatic hold_until_empty();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_VARIANT:   cfg_variant = data[1:0];
      CFG_TIMEOUT:   cfg_timeout = data[7:0];
      CFG_IDEAL_MIN: cfg_lo = data;
      CFG_IDEAL_MAX: cfg_hi = data;
      default: ;
    endcase
  endtask

  // new register setting, only once the block has gone quiet;
  // unused upper bits of variant and timeout get random junk
  task automatic apply_setting(input logic [1:0] v, input logic [7:0] t,
                               input logic [15:0] lo, input logic [15:0] hi);
    logic [CFG_DATA_W-1:0] junk;
    hold_until_empty();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    junk = 16'($urandom);
    write_reg(CFG_VARIANT, {junk[15:2], v});
    write_reg(CFG_TIMEOUT, {junk[15:8], t});
    write_reg(CFG_IDEAL_MIN, lo);
    write_reg(CFG_IDEAL_MAX, hi);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly a letter then a well-formed number, sometimes broken or plain noise
  task automatic random_command();
    int unsigned pick;
    int unsigned n_tick;
    logic [7:0]  ch;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      // raw noise: any byte, any tick
      repeat ($urandom_range(1, 8))
        issue(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, '0);
      return;
    end
    case (pick % 8)
      0: ch = CH_P;
      1: ch = CH_I;
      2: ch = CH_D;
      3: ch = CH_V;
      4, 5: ch = CH_X;
      6: ch = CH_S;
      default: ch = $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range("a", "z"));
    endcase
    issue(REQ_BYTE, ch, 1'b0, '0);
    if ($urandom_range(0, 1)) issue(REQ_BYTE, CH_MINUS, 1'b0, '0);
    // long integer parts push the saturation
    send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 4));
    if ($urandom_range(0, 2) != 0) begin
      issue(REQ_BYTE, CH_DOT, 1'b0, '0);
      send_digits(($urandom_range(0, 3) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 3));
    end
    // maybe malformed tail: stray sign or dot, then digits, ignored where it breaks the number
    if ($urandom_range(0, 7) == 0) begin
      issue(REQ_BYTE, $urandom_range(0, 1) ? CH_MINUS : CH_DOT, 1'b0, '0);
      send_digits($urandom_range(0, 2));
    end
    // silence: just short of the timeout, just past it, or a few ticks
    case ($urandom_range(0, 9))
      0: n_tick = cfg_timeout + $urandom_range(1, 3);
      1: n_tick = cfg_timeout;
      default: n_tick = $urandom_range(0, 2);
    endcase
    repeat (n_tick) issue(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  initial begin : stimulus
    int unsigned quota;

    // predictor at its reset state
    cfg_variant = VARIANT_RST;
    cfg_timeout = TIMEOUT_RST;
    cfg_lo      = IDEAL_MIN_RST;
    cfg_hi      = IDEAL_MAX_RST;
    pend_letter = CH_SPACE;
    quiet_ticks = '0;
    clear_number();

    // directed words with the reset setting
    add_word(REQ_TICK, CH_SPACE);          // tick with nothing pending
    add_word(REQ_BYTE, "4");               // digits ahead of any letter are dropped
    add_word(REQ_BYTE, CH_V);
    add_word(REQ_BYTE, CH_MINUS);
    add_word(REQ_BYTE, CH_ZERO);
    // minus zero keeps its sign
    add_checked(CH_P, TGT_SPEED, 1'b1, '0, '0, '0, 32'sd0);
    add_word(REQ_BYTE, CH_DOT);
    repeat (7) add_word(REQ_BYTE, CH_NINE);
    // seventh fraction digit dropped, fraction at its largest value
    add_checked(CH_X, TGT_P_GAIN, 1'b0, '0, 20'd999999, 3'd6, 32'sd0);
    add_word(REQ_BYTE, "5");
    add_word(REQ_BYTE, CH_ZERO);
    add_word(REQ_BYTE, CH_ZERO);
    // top of the position span maps to ideal_max
    add_checked(CH_S, TGT_POSITION, 1'b0, 27'd500, '0, '0, 32'sd1000);
    add_word(REQ_BYTE, CH_MINUS);
    add_word(REQ_BYTE, CH_DOT);
    add_word(REQ_BYTE, CH_MINUS);          // breaks the number
    add_word(REQ_BYTE, "8");               // ignored after the break
    add_checked("x", TGT_SUCTION, 1'b1, '0, '0, '0, 32'sd0);
    add_word(REQ_BYTE, CH_I);              // lowercase letter runs nothing
    add_checked(CH_D, TGT_I_GAIN, 1'b0, '0, '0, '0, 32'sd0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[k])
      issue(stim_rows[k].req, stim_rows[k].ch, stim_rows[k].typed, stim_rows[k].want);

    // random phases: each after the first applies its own setting; idle and stall rates cycle through four patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: apply_setting(2'd0, 8'd0, 16'h8000, 16'h7fff);
        2: apply_setting(2'd1, 8'd255, 16'h7fff, 16'h8000);
        3: apply_setting(2'd3, 8'd1, 16'h0000, 16'h0000);
        4: apply_setting(2'd2, 8'd3, 16'h8000, 16'h7fff);
        5: apply_setting(2'd1, 8'($urandom_range(0, 12)), 16'($urandom), 16'($urandom));
        6: apply_setting(2'd3, 8'($urandom_range(0, 12)), 16'($urandom), 16'($urandom));
        7: apply_setting(2'd2, 8'd2, 16'd1000, -16'sd1000);
        default: ;
      endcase
      case (ph % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 56;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 56;
        end
        default: begin
          idle_pct  = 10;
          stall_pct = 10;
        end
      endcase
      quota = words_sent + PHASE_WORDS;
      while (words_sent < quota) begin
        random_command();
        if ($urandom_range(0, 39) == 0) hold_until_empty();
      end
    end

    // let the pipeline drain, then a few spare cycles for strays
    hold_until_empty();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
